[hdl/bnsq_pkg.sv]
`timescale 1ns / 1ps
// types and constants shared by the buzzer note sequencer queue
package bnsq_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [7:0] REST_MS_RESET      = 8'd10;
    localparam logic [7:0] TICKS_PER_MS_RESET = 8'd10;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_ADD    = 3'd1,
        OP_EXPIRE = 3'd2,
        OP_STOP   = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_REST_MS      = 1'b0,
        REG_TICKS_PER_MS = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_PLAY = 2'd1,
        MODE_LOOP = 2'd2,
        MODE_STOP = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EXEC,
        ST_POP,
        ST_MUL,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_ADD,
        CMD_POP,
        CMD_PHASE,
        CMD_RESTART,
        CMD_END,
        CMD_STOP,
        CMD_CLEAR
    } cmd_t;

    typedef enum logic [2:0] {
        RES_START,
        RES_NEXT,
        RES_DONE,
        RES_CLEAR,
        RES_PHASE
    } res_t;

    typedef struct packed {
        logic       rest;
        logic       loop;
        logic [8:0] length;
        logic [7:0] start;
    } desc_t;

    typedef struct packed {
        logic [15:0] duration;
        logic [15:0] pitch;
    } note_t;

    typedef struct packed {
        logic capture;
        logic reduce_step;
        cmd_t cmd;
        logic mul;
        logic emit;
        res_t res;
    } ctrl_t;

    typedef struct packed {
        logic [2:0] op;
        logic       reduced;
        logic       mode_none;
        logic       phase_avail;
        logic       loop_mode;
        logic       queue_empty;
        logic       out_free;
    } stat_t;

endpackage

[hdl/bnsq_ram.sv]
`timescale 1ns / 1ps
// generic single write port ram with registered read
module bnsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/bnsq_datapath.sv]
`timescale 1ns / 1ps
// datapath: request latch, effect queue, playing effect, note memory, reload and result
module bnsq_datapath #(
    parameter int NOTE_DEPTH  = 256,
    parameter int QUEUE_DEPTH = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bnsq_pkg::ctrl_t                 ctrl,
    output bnsq_pkg::stat_t                 stat,
    input  logic                            cfg_write,
    input  logic [bnsq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bnsq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [2:0]                      op,
    input  logic [7:0]                      address,
    input  logic [15:0]                     pitch,
    input  logic [15:0]                     duration_ms,
    input  logic [8:0]                      length,
    input  logic                            emergency,
    input  logic                            circulating,
    input  logic                            add_rest,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            tone_on,
    output logic [15:0]                     tone_pitch,
    output logic                            timer_run,
    output logic [23:0]                     reload_ticks,
    output logic                            reload_valid,
    output logic                            effect_done
);

    import bnsq_pkg::*;

    localparam int AW = $clog2(NOTE_DEPTH);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [7:0] NOTE_DEPTH_LO = 8'(NOTE_DEPTH);

    // latched request
    logic [2:0]  op_reg;
    logic [7:0]  addr_reg;
    logic [15:0] pitch_in_reg;
    logic [15:0] dur_in_reg;
    logic [8:0]  length_reg;
    logic        urgent_reg;
    logic        loop_reg;
    logic        rest_reg;

    logic [7:0] rest_ms_reg;
    logic [7:0] tpm_reg;

    desc_t          queue_mem [QUEUE_DEPTH];
    logic [QW-1:0]  head_reg, head_next;
    logic [CW-1:0]  count_reg, count_next;
    desc_t          cur_reg, cur_next;
    mode_t          mode_reg, mode_next;
    logic [9:0]     progress_reg, progress_next;
    logic [AW-1:0]  ptr_reg, ptr_next;

    logic [15:0] dur_reg;
    logic [15:0] pitch_reg;
    logic        is_rest_reg;
    logic [23:0] prod_reg;

    logic        out_valid_reg;
    logic        tone_on_reg;
    logic [15:0] tone_pitch_reg;
    logic        timer_run_reg;
    logic [23:0] reload_ticks_reg;
    logic        reload_valid_reg;
    logic        effect_done_reg;

    logic [31:0]   ram_q;
    note_t         note;
    desc_t         desc_in;
    desc_t         head_desc;
    logic          reduced;
    logic [9:0]    total;
    logic          phase_avail;
    logic          is_rest;
    logic [15:0]   dur_sel;
    logic [QW-1:0] head_inc;
    logic [QW-1:0] head_dec;
    logic [SW-1:0] tail_sum;
    logic [QW-1:0] tail;
    logic          full;
    logic          q_we;
    logic [QW-1:0] q_waddr;
    logic [AW-1:0] ptr_inc;
    logic [23:0]   reload;
    logic          out_free;

    logic        res_tone_on;
    logic [15:0] res_pitch;
    logic        res_run;
    logic [23:0] res_reload;
    logic        res_valid;
    logic        res_done;

    bnsq_ram #(
        .WIDTH (32),
        .DEPTH (NOTE_DEPTH)
    ) u_note_ram (
        .clk   (clk),
        .we    (ctrl.cmd == CMD_LOAD),
        .waddr (AW'(addr_reg)),
        .wdata ({dur_in_reg, pitch_in_reg}),
        .raddr (ptr_reg),
        .rdata (ram_q)
    );

    assign note      = note_t'(ram_q);
    assign desc_in   = '{rest: rest_reg, loop: loop_reg, length: length_reg, start: addr_reg};
    assign head_desc = queue_mem[head_reg];

    assign reduced = (NOTE_DEPTH >= 256) || (int'(addr_reg) < NOTE_DEPTH);

    assign total       = cur_reg.rest ? {cur_reg.length, 1'b0} : {1'b0, cur_reg.length};
    assign phase_avail = (progress_reg < total) &&
                         ((mode_reg == MODE_PLAY) || (mode_reg == MODE_LOOP));
    assign is_rest     = cur_reg.rest && progress_reg[0];

    always_comb
    begin
        if (is_rest)
        begin
            dur_sel = {8'd0, rest_ms_reg};
        end
        else if (note.duration <= {8'd0, rest_ms_reg})
        begin
            dur_sel = note.duration;
        end
        else
        begin
            dur_sel = note.duration - {8'd0, rest_ms_reg};
        end
    end

    assign head_inc = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QW'(1);
    assign head_dec = (head_reg == '0) ? QW'(QUEUE_DEPTH - 1) : head_reg - QW'(1);
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? QW'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : QW'(tail_sum);
    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign ptr_inc  = (ptr_reg == AW'(NOTE_DEPTH - 1)) ? '0 : ptr_reg + AW'(1);

    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        cur_next      = cur_reg;
        mode_next     = mode_reg;
        progress_next = progress_reg;
        ptr_next      = ptr_reg;
        q_we          = 1'b0;
        q_waddr       = tail;
        unique case (ctrl.cmd)
            CMD_ADD:
            begin
                q_we = 1'b1;
                if (urgent_reg)
                begin
                    head_next = head_dec;
                    q_waddr   = head_dec;
                    if (!full)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                else if (full)
                begin
                    // oldest waiting request is overwritten
                    q_waddr   = head_reg;
                    head_next = head_inc;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_POP:
            begin
                cur_next      = head_desc;
                head_next     = head_inc;
                count_next    = count_reg - CW'(1);
                mode_next     = head_desc.loop ? MODE_LOOP : MODE_PLAY;
                progress_next = '0;
                ptr_next      = AW'(head_desc.start);
            end
            CMD_PHASE:
            begin
                progress_next = progress_reg + 10'd1;
                if (!cur_reg.rest || progress_reg[0])
                begin
                    ptr_next = ptr_inc;
                end
            end
            CMD_RESTART:
            begin
                progress_next = '0;
                ptr_next      = AW'(cur_reg.start);
            end
            CMD_END:
            begin
                mode_next     = MODE_NONE;
                cur_next      = '0;
                progress_next = '0;
            end
            CMD_STOP:
            begin
                if (mode_reg != MODE_NONE)
                begin
                    mode_next = MODE_STOP;
                end
            end
            CMD_CLEAR:
            begin
                head_next     = '0;
                count_next    = '0;
                mode_next     = MODE_NONE;
                cur_next      = '0;
                progress_next = '0;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            cur_reg      <= '0;
            mode_reg     <= MODE_NONE;
            progress_reg <= '0;
            ptr_reg      <= '0;
        end
        else
        begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            cur_reg      <= cur_next;
            mode_reg     <= mode_next;
            progress_reg <= progress_next;
            ptr_reg      <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[q_waddr] <= desc_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_ms_reg <= REST_MS_RESET;
            tpm_reg     <= TICKS_PER_MS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_REST_MS:      rest_ms_reg <= cfg_data;
                REG_TICKS_PER_MS: tpm_reg     <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            op_reg       <= op;
            addr_reg     <= address;
            pitch_in_reg <= pitch;
            dur_in_reg   <= duration_ms;
            length_reg   <= length;
            urgent_reg   <= emergency;
            loop_reg     <= circulating;
            rest_reg     <= add_rest;
        end
        else if (ctrl.reduce_step)
        begin
            addr_reg <= addr_reg - NOTE_DEPTH_LO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cmd == CMD_PHASE)
        begin
            dur_reg     <= dur_sel;
            pitch_reg   <= note.pitch;
            is_rest_reg <= is_rest;
        end
        if (ctrl.mul)
        begin
            prod_reg <= {8'd0, dur_reg} * {16'd0, tpm_reg};
        end
    end

    // zero product saturates at zero
    assign reload = (prod_reg == 24'd0) ? 24'd0 : prod_reg - 24'd1;

    always_comb
    begin
        res_tone_on = 1'b0;
        res_pitch   = '0;
        res_run     = 1'b0;
        res_reload  = '0;
        res_valid   = 1'b0;
        res_done    = 1'b0;
        unique case (ctrl.res)
            RES_START:
            begin
                res_run    = 1'b1;
                res_reload = 24'd1;
                res_valid  = 1'b1;
            end
            RES_NEXT:
            begin
                res_run    = 1'b1;
                res_reload = 24'd1;
                res_valid  = 1'b1;
                res_done   = 1'b1;
            end
            RES_DONE:
            begin
                res_done = 1'b1;
            end
            RES_PHASE:
            begin
                res_tone_on = !is_rest_reg;
                res_pitch   = is_rest_reg ? 16'd0 : pitch_reg;
                res_run     = 1'b1;
                res_reload  = reload;
                res_valid   = 1'b1;
            end
            default:
            begin
                res_done = 1'b0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            tone_on_reg      <= res_tone_on;
            tone_pitch_reg   <= res_pitch;
            timer_run_reg    <= res_run;
            reload_ticks_reg <= res_reload;
            reload_valid_reg <= res_valid;
            effect_done_reg  <= res_done;
        end
    end

    assign stat.op          = op_reg;
    assign stat.reduced     = reduced;
    assign stat.mode_none   = (mode_reg == MODE_NONE);
    assign stat.phase_avail = phase_avail;
    assign stat.loop_mode   = (mode_reg == MODE_LOOP);
    assign stat.queue_empty = (count_reg == '0);
    assign stat.out_free    = out_free;

    assign out_valid    = out_valid_reg;
    assign tone_on      = tone_on_reg;
    assign tone_pitch   = tone_pitch_reg;
    assign timer_run    = timer_run_reg;
    assign reload_ticks = reload_ticks_reg;
    assign reload_valid = reload_valid_reg;
    assign effect_done  = effect_done_reg;

endmodule

[hdl/bnsq_ctrl.sv]
`timescale 1ns / 1ps
// controller state machine sequencing one request at a time
module bnsq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  bnsq_pkg::stat_t stat,
    output bnsq_pkg::ctrl_t ctrl
);

    import bnsq_pkg::*;

    state_t state_reg, state_next;
    res_t   res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            res_reg   <= RES_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (stat.reduced)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                unique case (stat.op)
                    OP_ADD:
                    begin
                        if (stat.mode_none)
                        begin
                            state_next = ST_POP;
                            res_next   = RES_START;
                        end
                    end
                    OP_EXPIRE:
                    begin
                        if (stat.mode_none)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (stat.phase_avail)
                        begin
                            state_next = ST_MUL;
                            res_next   = RES_PHASE;
                        end
                        else if (stat.loop_mode)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (!stat.queue_empty)
                        begin
                            state_next = ST_POP;
                            res_next   = RES_NEXT;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                            res_next   = RES_DONE;
                        end
                    end
                    OP_CLEAR:
                    begin
                        state_next = ST_EMIT;
                        res_next   = RES_CLEAR;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_POP:
            begin
                state_next = ST_EMIT;
            end
            ST_MUL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl.capture     = 1'b0;
        ctrl.reduce_step = 1'b0;
        ctrl.cmd         = CMD_NONE;
        ctrl.mul         = 1'b0;
        ctrl.emit        = 1'b0;
        ctrl.res         = res_reg;
        in_stall         = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.capture = in_valid;
            end
            ST_REDUCE:
            begin
                ctrl.reduce_step = !stat.reduced;
            end
            ST_EXEC:
            begin
                unique case (stat.op)
                    OP_LOAD:  ctrl.cmd = CMD_LOAD;
                    OP_ADD:   ctrl.cmd = CMD_ADD;
                    OP_STOP:  ctrl.cmd = CMD_STOP;
                    OP_CLEAR: ctrl.cmd = CMD_CLEAR;
                    OP_EXPIRE:
                    begin
                        if (stat.mode_none)
                        begin
                            ctrl.cmd = CMD_NONE;
                        end
                        else if (stat.phase_avail)
                        begin
                            ctrl.cmd = CMD_PHASE;
                        end
                        else if (stat.loop_mode)
                        begin
                            ctrl.cmd = CMD_RESTART;
                        end
                        else if (stat.queue_empty)
                        begin
                            ctrl.cmd = CMD_END;
                        end
                        else
                        begin
                            ctrl.cmd = CMD_NONE;
                        end
                    end
                    default:  ctrl.cmd = CMD_NONE;
                endcase
            end
            ST_POP:
            begin
                ctrl.cmd = CMD_POP;
            end
            ST_MUL:
            begin
                ctrl.mul = 1'b1;
            end
            ST_EMIT:
            begin
                ctrl.emit = stat.out_free;
            end
            default:
            begin
                ctrl.emit = 1'b0;
            end
        endcase
    end

endmodule

[hdl/buzzer_note_sequencer_queue_core.sv]
`timescale 1ns / 1ps
// top level of the buzzer note sequencer queue
// one request at a time: accept, address reduction, execute, optional pop or multiply, result
// address reduction subtracts NOTE_DEPTH, when below 256, until the address is below NOTE_DEPTH
// clear, retire: execute then result; start, next: via pop; note or rest: via multiply
// requests without result return to idle from execute; a request is taken only in idle
// reset clears queue pointers, playing effect and output valid; config returns to 10 and 10
module buzzer_note_sequencer_queue_core #(
    parameter int NOTE_DEPTH  = 256,
    parameter int QUEUE_DEPTH = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [bnsq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bnsq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [2:0]                       op,
    input  logic [7:0]                       address,
    input  logic [15:0]                      pitch,
    input  logic [15:0]                      duration_ms,
    input  logic [8:0]                       length,
    input  logic                             emergency,
    input  logic                             circulating,
    input  logic                             add_rest,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             tone_on,
    output logic [15:0]                      tone_pitch,
    output logic                             timer_run,
    output logic [23:0]                      reload_ticks,
    output logic                             reload_valid,
    output logic                             effect_done
);

    import bnsq_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    bnsq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    bnsq_datapath #(
        .NOTE_DEPTH  (NOTE_DEPTH),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .op           (op),
        .address      (address),
        .pitch        (pitch),
        .duration_ms  (duration_ms),
        .length       (length),
        .emergency    (emergency),
        .circulating  (circulating),
        .add_rest     (add_rest),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tone_on      (tone_on),
        .tone_pitch   (tone_pitch),
        .timer_run    (timer_run),
        .reload_ticks (reload_ticks),
        .reload_valid (reload_valid),
        .effect_done  (effect_done)
    );

endmodule

[hdl/bnsq_checker.sv]
`timescale 1ns / 1ps
// port level checks for the buzzer note sequencer queue, bound to the top level
module bnsq_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_write,
    input logic [bnsq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [bnsq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic [2:0]                       op,
    input logic [7:0]                       address,
    input logic [15:0]                      pitch,
    input logic [15:0]                      duration_ms,
    input logic [8:0]                       length,
    input logic                             emergency,
    input logic                             circulating,
    input logic                             add_rest,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic                             tone_on,
    input logic [15:0]                      tone_pitch,
    input logic                             timer_run,
    input logic [23:0]                      reload_ticks,
    input logic                             reload_valid,
    input logic                             effect_done
);

    // one request in flight
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while previous one in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tone_pitch) &&
        $stable(reload_ticks) && $stable(tone_on) && $stable(effect_done))
        else $error("stalled result changed");

    a_silent_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tone_on |-> tone_pitch == 16'd0)
        else $error("pitch given while silent");

    a_reload_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (reload_valid == timer_run) && (reload_valid || reload_ticks == 24'd0))
        else $error("reload and timer run disagree");

    a_tone_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tone_on |-> !effect_done && reload_valid)
        else $error("tone sounded with effect retire");

endmodule

bind buzzer_note_sequencer_queue_core bnsq_checker u_checker (.*);
